// File: design/max_flow_augmenting_paths_top_assert.svh
// assertion macros for the max flow block
`ifndef MAX_FLOW_AUGMENTING_PATHS_TOP_ASSERT_SVH
`define MAX_FLOW_AUGMENTING_PATHS_TOP_ASSERT_SVH

// same-cycle implication
`define MFA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mfa assertion failed");

// next-cycle implication
`define MFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mfa assertion failed");

// delayed implication
`define MFA_ASSERT_LATER(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("mfa assertion failed");

`endif

// File: design/mfa_pkg.sv
// shared constants, codes and control types of the max flow block
`default_nettype none
package mfa_pkg;
   localparam int MAX_VERTICES = 64;
   localparam int CAP_WIDTH    = 16;
   localparam int VTX_W        = $clog2(MAX_VERTICES);
   localparam int CNT_W        = VTX_W + 1;
   localparam int ADDR_W       = 2 * VTX_W;
   localparam int CELLS        = MAX_VERTICES * MAX_VERTICES;
   localparam int FIELD_VTX_W  = 6;
   localparam int FIELD_CAP_W  = 16;
   localparam int CFG_COUNT_W  = 7;
   localparam int RUN_TOTAL_W  = 23;
   localparam int OUT_TOTAL_W  = 22;
   localparam int CSR_DATA_W   = 7;

   localparam logic [CFG_COUNT_W-1:0] COUNT_RESET  = CFG_COUNT_W'(64);
   localparam logic [FIELD_VTX_W-1:0] SOURCE_RESET = FIELD_VTX_W'(0);
   localparam logic [FIELD_VTX_W-1:0] SINK_RESET   = FIELD_VTX_W'(63);

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_RUN   = 2'd1,
      REQ_READ  = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_VCOUNT = 2'd0,
      CSR_SOURCE = 2'd1,
      CSR_SINK   = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_CAP_WR,
      OP_FLOW_RD,
      OP_RSP_READ,
      OP_RSP_PLAIN,
      OP_RUN_INIT,
      OP_SEARCH_INIT,
      OP_DEQ,
      OP_LOAD_U,
      OP_LOAD_BU,
      OP_SCAN_RD,
      OP_NEXT_V,
      OP_NEXT_U,
      OP_EVAL,
      OP_AUG_INIT,
      OP_PRED_RD,
      OP_AUG_RD,
      OP_AUG_WR,
      OP_TOTAL
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic terminals_ok;
      logic queue_has;
      logic v_end;
      logic v_visited;
      logic edge_ok;
      logic hit_sink;
      logic aug_end;
      logic pred_bad;
   } stat_type;
endpackage
`default_nettype wire

// File: design/mfa_ram.sv
// generic single port write, single port registered read memory
`default_nettype none
module mfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// File: design/mfa_dpath.sv
// datapath: matrix memories, search scratch memories and run registers
`default_nettype none
module mfa_dpath import mfa_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output stat_type                    stat,
   input  wire logic [FIELD_VTX_W-1:0] row_vertex,
   input  wire logic [FIELD_VTX_W-1:0] col_vertex,
   input  wire logic [FIELD_CAP_W-1:0] capacity_value,
   input  wire logic                   csr_we,
   input  wire logic [1:0]             csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic      [FIELD_CAP_W-1:0] flow_value,
   output logic      [OUT_TOTAL_W-1:0] total_flow
);
   localparam logic [CAP_WIDTH-1:0] CAP_ALL = '1;
   localparam logic [RUN_TOTAL_W-1:0] TOTAL_MAX = '1;
   localparam logic [OUT_TOTAL_W-1:0] OUT_MAX = '1;

   logic [CFG_COUNT_W-1:0] count_ff, count_in;
   logic [VTX_W-1:0]       src_ff, src_in, sink_ff, sink_in;
   logic [ADDR_W-1:0]      clr_ff, clr_in;
   logic [VTX_W-1:0]       u_ff, u_in;
   logic [CNT_W-1:0]       v_ff, v_in, head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]       steps_ff, steps_in;
   logic [CAP_WIDTH-1:0]   bu_ff, bu_in, bneck_ff, bneck_in;
   logic [RUN_TOTAL_W-1:0] total_ff, total_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [FIELD_CAP_W-1:0] rsp_flow_ff, rsp_flow_in;

   logic                   cap_we, flow_we, pred_we, bott_we, queue_we;
   logic [ADDR_W-1:0]      cap_wa, flow_wa, cap_ra, fa_ra, fb_ra;
   logic [CAP_WIDTH-1:0]   cap_wd, flow_wd;
   logic [VTX_W-1:0]       pred_wa, pred_ra, bott_wa, bott_ra, queue_wa, queue_ra;
   logic [CNT_W-1:0]       pred_wd;
   logic [CAP_WIDTH-1:0]   bott_wd;
   logic [VTX_W-1:0]       queue_wd;
   logic [CAP_WIDTH-1:0]   cap_q, fa_q, fb_q, bott_q;
   logic [CNT_W-1:0]       pred_q;
   logic [VTX_W-1:0]       queue_q;

   logic [CNT_W-1:0]       n_eff;
   logic [VTX_W-1:0]       v_idx, u_src, row_v, col_v;
   logic                   fwd;
   logic [CAP_WIDTH-1:0]   room, b_new;
   logic [RUN_TOTAL_W:0]   total_sum;

   assign v_idx = v_ff[VTX_W-1:0];
   assign row_v = VTX_W'(row_vertex);
   assign col_v = VTX_W'(col_vertex);
   assign u_src = (cmd.op == OP_AUG_RD) ? pred_q[VTX_W-1:0] : u_ff;
   assign n_eff = (count_ff > CFG_COUNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                          : CNT_W'(count_ff);
   assign fwd   = fa_q < cap_q;
   assign room  = fwd ? (cap_q - fa_q) : fb_q;
   assign b_new = (bu_ff < room) ? bu_ff : room;
   assign total_sum = {1'b0, total_ff} + (RUN_TOTAL_W+1)'(bneck_ff);

   always_comb begin
      stat.clr_done     = &clr_ff;
      stat.terminals_ok = (CNT_W'(src_ff) < n_eff) && (CNT_W'(sink_ff) < n_eff)
                          && (src_ff != sink_ff);
      stat.queue_has    = (head_ff < tail_ff) && (head_ff < CNT_W'(MAX_VERTICES));
      stat.v_end        = v_ff >= n_eff;
      stat.v_visited    = visited_ff[v_idx];
      stat.edge_ok      = fwd || (fb_q != '0);
      stat.hit_sink     = v_idx == sink_ff;
      stat.aug_end      = (v_idx == src_ff) || (steps_ff >= n_eff);
      stat.pred_bad     = pred_q >= CNT_W'(MAX_VERTICES);
   end

   always_comb begin
      count_in = count_ff;
      src_in   = src_ff;
      sink_in  = sink_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_VCOUNT: count_in = csr_wdata;
            CSR_SOURCE: src_in   = VTX_W'(csr_wdata);
            CSR_SINK:   sink_in  = VTX_W'(csr_wdata);
            default:    count_in = count_ff;
         endcase
      end
   end

   always_comb begin
      clr_in      = clr_ff;
      u_in        = u_ff;
      v_in        = v_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      steps_in    = steps_ff;
      bu_in       = bu_ff;
      bneck_in    = bneck_ff;
      total_in    = total_ff;
      visited_in  = visited_ff;
      rsp_flow_in = rsp_flow_ff;
      cap_we = 1'b0;   cap_wa = '0;  cap_wd = '0;
      flow_we = 1'b0;  flow_wa = '0; flow_wd = '0;
      pred_we = 1'b0;  pred_wa = '0; pred_wd = '0;
      bott_we = 1'b0;  bott_wa = '0; bott_wd = '0;
      queue_we = 1'b0; queue_wa = '0; queue_wd = '0;
      cap_ra = '0; fa_ra = '0; fb_ra = '0;
      pred_ra = '0; bott_ra = '0; queue_ra = '0;
      case (cmd.op)
         OP_CLEAR: begin
            cap_we  = 1'b1;
            cap_wa  = clr_ff;
            flow_we = 1'b1;
            flow_wa = clr_ff;
            clr_in  = clr_ff + ADDR_W'(1);
         end
         OP_CAP_WR: begin
            cap_we = 1'b1;
            cap_wa = {row_v, col_v};
            cap_wd = CAP_WIDTH'(capacity_value);
         end
         OP_FLOW_RD:   fa_ra = {row_v, col_v};
         OP_RSP_READ:  rsp_flow_in = FIELD_CAP_W'(fa_q);
         OP_RSP_PLAIN: rsp_flow_in = '0;
         OP_RUN_INIT:  total_in = '0;
         OP_SEARCH_INIT: begin
            visited_in          = '0;
            visited_in[src_ff]  = 1'b1;
            bott_we  = 1'b1;
            bott_wa  = src_ff;
            bott_wd  = CAP_ALL;
            queue_we = 1'b1;
            queue_wa = '0;
            queue_wd = src_ff;
            head_in  = '0;
            tail_in  = CNT_W'(1);
         end
         OP_DEQ: queue_ra = head_ff[VTX_W-1:0];
         OP_LOAD_U: begin
            u_in    = queue_q;
            bott_ra = queue_q;
            v_in    = '0;
         end
         OP_LOAD_BU: bu_in = bott_q;
         OP_SCAN_RD, OP_AUG_RD: begin
            cap_ra = {u_src, v_idx};
            fa_ra  = {u_src, v_idx};
            fb_ra  = {v_idx, u_src};
            u_in   = u_src;
         end
         OP_NEXT_V: v_in = v_ff + CNT_W'(1);
         OP_NEXT_U: head_in = head_ff + CNT_W'(1);
         OP_EVAL: begin
            if (stat.edge_ok) begin
               visited_in[v_idx] = 1'b1;
               pred_we  = 1'b1;
               pred_wa  = v_idx;
               pred_wd  = CNT_W'(u_ff);
               bott_we  = 1'b1;
               bott_wa  = v_idx;
               bott_wd  = b_new;
               bneck_in = b_new;
               if (tail_ff < CNT_W'(MAX_VERTICES)) begin
                  queue_we = 1'b1;
                  queue_wa = tail_ff[VTX_W-1:0];
                  queue_wd = v_idx;
                  tail_in  = tail_ff + CNT_W'(1);
               end
            end
            if (!(stat.edge_ok && stat.hit_sink)) begin
               v_in = v_ff + CNT_W'(1);
            end
         end
         OP_AUG_INIT: begin
            v_in     = CNT_W'(sink_ff);
            steps_in = '0;
         end
         OP_PRED_RD: pred_ra = v_idx;
         OP_AUG_WR: begin
            flow_we = 1'b1;
            if (fwd) begin
               flow_wa = {u_ff, v_idx};
               flow_wd = fa_q + bneck_ff;
            end else begin
               flow_wa = {v_idx, u_ff};
               flow_wd = fb_q - bneck_ff;
            end
            v_in     = CNT_W'(u_ff);
            steps_in = steps_ff + CNT_W'(1);
         end
         OP_TOTAL: begin
            total_in = (total_sum > (RUN_TOTAL_W+1)'(TOTAL_MAX)) ? TOTAL_MAX
                                                                 : total_sum[RUN_TOTAL_W-1:0];
         end
         default: clr_in = clr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= COUNT_RESET;
         src_ff     <= VTX_W'(SOURCE_RESET);
         sink_ff    <= VTX_W'(SINK_RESET);
         clr_ff     <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         total_ff   <= '0;
         visited_ff <= '0;
      end else begin
         count_ff   <= count_in;
         src_ff     <= src_in;
         sink_ff    <= sink_in;
         clr_ff     <= clr_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         total_ff   <= total_in;
         visited_ff <= visited_in;
      end
      u_ff        <= u_in;
      v_ff        <= v_in;
      steps_ff    <= steps_in;
      bu_ff       <= bu_in;
      bneck_ff    <= bneck_in;
      rsp_flow_ff <= rsp_flow_in;
   end

   assign flow_value = rsp_flow_ff;
   assign total_flow = (total_ff > RUN_TOTAL_W'(OUT_MAX)) ? OUT_MAX
                                                          : total_ff[OUT_TOTAL_W-1:0];

   mfa_ram #(.WIDTH(CAP_WIDTH), .DEPTH(CELLS)) u_cap (
      .clock(clock), .wr_en(cap_we), .wr_addr(cap_wa), .wr_data(cap_wd),
      .rd_addr(cap_ra), .rd_data(cap_q)
   );

   // two copies of the flow matrix give the forward and reverse entries at once
   mfa_ram #(.WIDTH(CAP_WIDTH), .DEPTH(CELLS)) u_flow_a (
      .clock(clock), .wr_en(flow_we), .wr_addr(flow_wa), .wr_data(flow_wd),
      .rd_addr(fa_ra), .rd_data(fa_q)
   );

   mfa_ram #(.WIDTH(CAP_WIDTH), .DEPTH(CELLS)) u_flow_b (
      .clock(clock), .wr_en(flow_we), .wr_addr(flow_wa), .wr_data(flow_wd),
      .rd_addr(fb_ra), .rd_data(fb_q)
   );

   mfa_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES)) u_pred (
      .clock(clock), .wr_en(pred_we), .wr_addr(pred_wa), .wr_data(pred_wd),
      .rd_addr(pred_ra), .rd_data(pred_q)
   );

   mfa_ram #(.WIDTH(CAP_WIDTH), .DEPTH(MAX_VERTICES)) u_bott (
      .clock(clock), .wr_en(bott_we), .wr_addr(bott_wa), .wr_data(bott_wd),
      .rd_addr(bott_ra), .rd_data(bott_q)
   );

   mfa_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_queue (
      .clock(clock), .wr_en(queue_we), .wr_addr(queue_wa), .wr_data(queue_wd),
      .rd_addr(queue_ra), .rd_data(queue_q)
   );
endmodule
`default_nettype wire

// File: design/mfa_ctrl.sv
// controller: sequences clearing, requests, searches and augmentation
`default_nettype none
module mfa_ctrl import mfa_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire logic [1:0] req_kind,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output cmd_type       cmd,
   input  wire stat_type stat
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD, S_DONE, S_SEARCH, S_DEQ, S_LOADU, S_LOADBU,
      S_SCAN, S_EVAL, S_AUGINIT, S_AUG, S_AUG1, S_AUG2, S_TOTAL
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      fire;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign fire      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (fire) begin
               case (req_kind)
                  REQ_WRITE: begin
                     cmd.op   = OP_CAP_WR;
                     state_in = S_DONE;
                  end
                  REQ_RUN: begin
                     cmd.op   = OP_RUN_INIT;
                     state_in = S_SEARCH;
                  end
                  REQ_READ: begin
                     cmd.op   = OP_FLOW_RD;
                     state_in = S_RD;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_RD: begin
            cmd.op       = OP_RSP_READ;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_DONE: begin
            cmd.op       = OP_RSP_PLAIN;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_SEARCH: begin
            if (stat.terminals_ok) begin
               cmd.op   = OP_SEARCH_INIT;
               state_in = S_DEQ;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DEQ: begin
            if (stat.queue_has) begin
               cmd.op   = OP_DEQ;
               state_in = S_LOADU;
            end else begin
               state_in = S_DONE;
            end
         end
         S_LOADU: begin
            cmd.op   = OP_LOAD_U;
            state_in = S_LOADBU;
         end
         S_LOADBU: begin
            cmd.op   = OP_LOAD_BU;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (stat.v_end) begin
               cmd.op   = OP_NEXT_U;
               state_in = S_DEQ;
            end else if (stat.v_visited) begin
               cmd.op = OP_NEXT_V;
            end else begin
               cmd.op   = OP_SCAN_RD;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.op   = OP_EVAL;
            state_in = (stat.edge_ok && stat.hit_sink) ? S_AUGINIT : S_SCAN;
         end
         S_AUGINIT: begin
            cmd.op   = OP_AUG_INIT;
            state_in = S_AUG;
         end
         S_AUG: begin
            if (stat.aug_end) begin
               state_in = S_TOTAL;
            end else begin
               cmd.op   = OP_PRED_RD;
               state_in = S_AUG1;
            end
         end
         S_AUG1: begin
            if (stat.pred_bad) begin
               state_in = S_TOTAL;
            end else begin
               cmd.op   = OP_AUG_RD;
               state_in = S_AUG2;
            end
         end
         S_AUG2: begin
            cmd.op   = OP_AUG_WR;
            state_in = S_AUG;
         end
         S_TOTAL: begin
            cmd.op   = OP_TOTAL;
            state_in = S_SEARCH;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

// File: design/max_flow_augmenting_paths_top.sv
// top level of the edmonds-karp max flow block
//
//   port group   dir   meaning
//   req_*        in    request: write capacity, run max flow or read flow
//   rsp_*        out   one result per request: flow entry and run total
//   csr_*        in    register writes: vertex count, source, sink
//
// after reset a clearing pass zeroes both 4096-entry matrices, during which no request
// is taken; csr writes are taken throughout
// write and unknown requests answer through S_DONE, reads through S_RD, runs through
// S_DONE after the last search; each search starts from the source and, per dequeued
// vertex, loads it and its bottleneck, then scans the neighbors, skipping visited ones
// and reading and testing unvisited ones; a search with no path ends the run, a found
// path is walked back from the sink edge by edge, updating the flow, and its bottleneck
// is added to the total before the next search; registered memory reads set the pace
// one request is in flight at a time; a stalled result holds off new requests
`default_nettype none
module max_flow_augmenting_paths_top import mfa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // row_vertex, col_vertex, capacity_value
   input  wire logic [1:0]  req_tuser,  // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata,  // flow_value, total_flow
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [6:0]  csr_wdata
);
   cmd_type                cmd;
   stat_type               stat;
   logic [FIELD_CAP_W-1:0] flow_value;
   logic [OUT_TOTAL_W-1:0] total_flow;

   // sequencer
   mfa_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_tvalid), .req_ready(req_tready), .req_kind(req_tuser),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .cmd(cmd), .stat(stat)
   );

   // memories and run registers
   mfa_dpath u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .row_vertex(req_tdata[5:0]),
      .col_vertex(req_tdata[11:6]),
      .capacity_value(req_tdata[27:12]),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .flow_value(flow_value), .total_flow(total_flow)
   );

   // result packing, zero pad to whole bytes
   assign rsp_tdata = {2'b00, total_flow, flow_value};

`include "max_flow_augmenting_paths_top_assert.svh"

   // no new request while a result waits
   `MFA_ASSERT_NOW(a_ready_no_rsp, clock, reset, req_tready, !rsp_tvalid)
   // an accepted request closes the input until its result is out
   `MFA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   // a capacity write raises its result after passing through S_DONE
   `MFA_ASSERT_LATER(a_write_latency, clock, reset, req_tvalid && req_tready && (req_tuser == REQ_WRITE), rsp_tvalid)
endmodule
`default_nettype wire

// File: tb/tb.sv
// self-checking testbench of the max flow block: capacity writes, flow runs and flow reads
`default_nettype none
module tb;
   import mfa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // request code the block has no meaning for
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam int         NV          = MAX_VERTICES;
   localparam int         CYCLE_LIMIT = 8000000;
   localparam logic [22:0] RUN_SAT    = 23'h7FFFFF;
   localparam logic [21:0] OUT_SAT    = 22'h3FFFFF;

   typedef struct {
      logic [1:0]  kind;
      logic [5:0]  row;
      logic [5:0]  col;
      logic [15:0] cap;
   } flow_req_type;

   typedef struct {
      logic [15:0] flow;
      logic [21:0] total;
   } flow_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // row_vertex, col_vertex, capacity_value
   logic [1:0]  req_tuser = '0;  // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;       // flow_value, total_flow
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [6:0]  csr_wdata = '0;

   max_flow_augmenting_paths_top i_dut (.*);

   always #4 clock = ~clock;

   // pending requests and the results they are predicted to give
   flow_req_type pending_reqs[$];
   flow_rsp_type expected_rsps[$];
   int        mismatches = 0;
   int        rsp_count  = 0;

   // shadow of the block: registers, matrices and search scratch
   logic [6:0]  vcount_sh = 7'd64;
   logic [5:0]  source_sh = 6'd0;
   logic [5:0]  sink_sh   = 6'd63;
   logic [15:0] cap_mem  [NV*NV];
   logic [15:0] flow_mem [NV*NV];
   logic        seen     [NV];
   int          prev_vtx [NV];
   logic [15:0] bottle   [NV];
   int          bfs_fifo [NV];
   logic [22:0] run_sum  = '0;

   initial begin
      for (int i = 0; i < NV*NV; i++) begin
         cap_mem[i]  = '0;
         flow_mem[i] = '0;
      end
   end

   // breadth-first search over the residual graph, gives the path bottleneck or 0
   function automatic logic [15:0] find_path(int n);
      int u, v, head, tail;
      logic [15:0] fuv, cuv, fvu, room, b;
      for (int i = 0; i < NV; i++) begin
         seen[i]     = 1'b0;
         prev_vtx[i] = NV;
      end
      head = 0;
      tail = 0;
      if (source_sh >= n || sink_sh >= n || source_sh == sink_sh) return '0;
      seen[source_sh]   = 1'b1;
      bottle[source_sh] = 16'hFFFF;
      bfs_fifo[tail++]  = source_sh;
      while (head < tail && head < NV) begin
         u = bfs_fifo[head];
         for (v = 0; v < n; v++) begin
            fuv = flow_mem[u*NV+v];
            cuv = cap_mem[u*NV+v];
            fvu = flow_mem[v*NV+u];
            if (seen[v] || !(fuv < cuv || fvu > 0)) continue;
            // forward residual wins over back flow
            room = (fuv < cuv) ? cuv - fuv : fvu;
            b    = (bottle[u] < room) ? bottle[u] : room;
            seen[v]     = 1'b1;
            prev_vtx[v] = u;
            bottle[v]   = b;
            if (tail < NV) bfs_fifo[tail++] = v;
            if (v == sink_sh) return b;
         end
         head++;
      end
      return '0;
   endfunction

   // walk back from the sink, push forward or cancel reverse flow
   function automatic void push_path(logic [15:0] b, int n);
      int v, u, steps;
      v = sink_sh;
      steps = 0;
      while (v != source_sh && steps < n) begin
         u = prev_vtx[v];
         if (u >= NV) break;
         if (flow_mem[u*NV+v] < cap_mem[u*NV+v]) flow_mem[u*NV+v] += b;
         else flow_mem[v*NV+u] -= b;
         v = u;
         steps++;
      end
   endfunction

   function automatic flow_rsp_type predict_rsp(flow_req_type q);
      flow_rsp_type r;
      int          n;
      logic [15:0] b;
      logic [23:0] sum;
      r.flow = '0;
      case (q.kind)
         REQ_WRITE: cap_mem[q.row*NV+q.col] = q.cap;
         REQ_READ:  r.flow = flow_mem[q.row*NV+q.col];
         REQ_RUN: begin
            n = (vcount_sh > NV) ? NV : vcount_sh;
            run_sum = '0;
            b = find_path(n);
            while (b != 0) begin
               push_path(b, n);
               sum = {1'b0, run_sum} + b;
               run_sum = (sum > RUN_SAT) ? RUN_SAT : sum[22:0];
               b = find_path(n);
            end
         end
         default: ;
      endcase
      r.total = (run_sum > OUT_SAT) ? OUT_SAT : run_sum[21:0];
      return r;
   endfunction

   // sender: bursts of random length with random gaps, fed from pending_reqs
   int burst_left = 0;
   int gap_left   = 0;
   always @(posedge clock) begin
      logic      nxt_valid;
      flow_req_type q;
      nxt_valid = req_tvalid;
      if (req_tvalid && req_tready) begin
         q = pending_reqs.pop_front();
         expected_rsps.push_back(predict_rsp(q));
         nxt_valid = 1'b0;
      end
      if (!reset && !nxt_valid) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_reqs.size() > 0) begin
            q = pending_reqs[0];
            req_tdata <= {4'b0, q.cap, q.col, q.row};
            req_tuser <= q.kind;
            nxt_valid = 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 12);
               // about one burst in four runs back to back
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            end
         end
      end
      req_tvalid <= nxt_valid;
   end

   // receiver: stalls on its own pattern, one long hold-off to back up the input
   int  stall_mode  = 0;
   int  mode_left   = 0;
   int  hold_left   = 0;
   logic hold_done  = 1'b0;
   always @(posedge clock) begin
      flow_rsp_type e;
      if (rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_tdata[15:0] !== e.flow || rsp_tdata[37:16] !== e.total) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: flow exp %0d got %0d, total exp %0d got %0d",
                           rsp_count, e.flow, rsp_tdata[15:0], e.total, rsp_tdata[37:16]);
            end
         end
      end
      if (!hold_done && rsp_count == 60) begin
         hold_done = 1'b1;
         hold_left = 600;
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(20, 300);
      end else begin
         mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_mode == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, stall_mode + 1) == 0) ? 1'b0 : 1'b1;
      end
   end

   // watchdog
   int cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic add_req(logic [1:0] kind, int row, int col, int cap);
      flow_req_type q;
      q.kind = kind;
      q.row  = row[5:0];
      q.col  = col[5:0];
      q.cap  = cap[15:0];
      pending_reqs.push_back(q);
   endtask

   // waits until every request is sent and every result is in
   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[6:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_VCOUNT: vcount_sh = val[6:0];
         CSR_SOURCE: source_sh = val[5:0];
         default:    sink_sh   = val[5:0];
      endcase
   endtask

   task automatic set_graph(int vc, int src, int snk);
      write_reg(CSR_VCOUNT, vc);
      write_reg(CSR_SOURCE, src);
      write_reg(CSR_SINK, snk);
   endtask

   // one random phase: mostly small graphs, now and then the full matrix
   task automatic random_phase(int items);
      int sel, vc, lim, src, snk, k, row, col, cap;
      sel = $urandom_range(0, 9);
      if (sel == 0) vc = 64;
      else if (sel == 1) vc = $urandom_range(0, 127);
      else vc = $urandom_range(3, 8);
      lim = (vc > 64) ? 64 : ((vc < 1) ? 1 : vc);
      src = $urandom_range(0, lim - 1);
      snk = $urandom_range(0, lim - 1);
      if ($urandom_range(0, 7) == 0) snk = $urandom_range(0, 63);
      set_graph(vc, src, snk);
      for (int i = 0; i < items; i++) begin
         k   = $urandom_range(0, 19);
         row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, lim - 1);
         col = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, lim - 1);
         cap = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 20);
         // full-size graphs keep runs rare since each search is long
         if (k < 10) add_req(REQ_WRITE, row, col, cap);
         else if (k < 13 && (lim < 64 || k == 10)) add_req(REQ_RUN, 0, 0, 0);
         else if (k < 19) add_req(REQ_READ, row, col, 0);
         else add_req(REQ_UNKNOWN, row, col, cap);
      end
      add_req(REQ_RUN, 0, 0, 0);
      wait_idle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset registers: full matrix, source 0, sink 63, single big edge
      add_req(REQ_READ, 63, 0, 0);
      add_req(REQ_RUN, 0, 0, 0);
      add_req(REQ_WRITE, 0, 63, 65535);
      add_req(REQ_WRITE, 63, 63, 1);
      add_req(REQ_RUN, 0, 0, 0);
      add_req(REQ_READ, 0, 63, 0);
      add_req(REQ_UNKNOWN, 63, 63, 65535);
      add_req(REQ_READ, 63, 63, 0);
      wait_idle();

      // two-vertex graph, sink below source, then stale flow over a shrunk edge
      set_graph(2, 1, 0);
      add_req(REQ_WRITE, 1, 0, 5);
      add_req(REQ_RUN, 0, 0, 0);
      add_req(REQ_READ, 1, 0, 0);
      add_req(REQ_WRITE, 1, 0, 2);
      add_req(REQ_RUN, 0, 0, 0);
      add_req(REQ_READ, 1, 0, 0);
      wait_idle();

      // source equals sink, then counts of zero and one and an oversized count
      set_graph(4, 2, 2);
      add_req(REQ_RUN, 0, 0, 0);
      wait_idle();
      write_reg(CSR_VCOUNT, 0);
      write_reg(CSR_SINK, 1);
      add_req(REQ_RUN, 0, 0, 0);
      wait_idle();
      write_reg(CSR_VCOUNT, 1);
      add_req(REQ_RUN, 0, 0, 0);
      wait_idle();
      set_graph(127, 0, 63);
      add_req(REQ_RUN, 0, 0, 0);
      add_req(REQ_READ, 0, 63, 0);
      wait_idle();

      // back flow: path 0-1-2-3 then two cross edges whose path cancels 1->2
      set_graph(4, 0, 3);
      add_req(REQ_WRITE, 0, 1, 3);
      add_req(REQ_WRITE, 1, 2, 3);
      add_req(REQ_WRITE, 2, 3, 3);
      add_req(REQ_RUN, 0, 0, 0);
      add_req(REQ_WRITE, 0, 2, 2);
      add_req(REQ_WRITE, 1, 3, 2);
      add_req(REQ_RUN, 0, 0, 0);
      add_req(REQ_READ, 1, 2, 0);
      wait_idle();

      for (int p = 0; p < 10; p++) random_phase($urandom_range(30, 45));

      wait_idle();
      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire
